// ===== src/swis_pkg.sv =====
// Package: types, command codes and microcode table for the sorting stack.
`timescale 1ns / 1ps
`default_nettype none

package swis_pkg;

	// Widths fixed by the transaction fields
	localparam int WORD_W        = 32;
	localparam int CMD_W         = 2;
	localparam int ENTRY_CNT_W   = 5;
	localparam int DEPTH_DEFAULT = 16;
	localparam int STEP_W        = 4;

	// Command codes; the fourth code is a no-operation
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SORT = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [WORD_W-1:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  popped_value;
		logic signed [WORD_W-1:0]  top_value;
		logic signed [WORD_W-1:0]  past_top;
		logic [ENTRY_CNT_W-1:0]    entry_count;
		logic                      is_full;
		logic                      is_empty;
		logic                      error;
	} rsp_item_t;

	// Sequencer steps (program addresses)
	typedef enum logic [STEP_W-1:0] {
		ST_FETCH = 4'd0,
		ST_PUSH  = 4'd1,
		ST_POP   = 4'd2,
		ST_NOP   = 4'd3,
		ST_SINIT = 4'd4,
		ST_OUTER = 4'd5,
		ST_KEY   = 4'd6,
		ST_CMP   = 4'd7,
		ST_PLACE = 4'd8,
		ST_TOP   = 4'd9
	} step_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		OP_FETCH,
		OP_PUSH,
		OP_POP,
		OP_NOP,
		OP_SORT_INIT,
		OP_OUTER,
		OP_KEY,
		OP_SHIFT,
		OP_PLACE,
		OP_TOP
	} op_t;

	// Sequencing: fall through, jump, dispatch on command, or conditional jump
	typedef enum logic [2:0] {
		SEQ_NEXT,
		SEQ_JUMP,
		SEQ_DISPATCH,
		SEQ_IF_SORTED,
		SEQ_IF_SHIFT_MORE
	} seq_t;

	typedef struct packed {
		op_t   op;
		seq_t  seq;
		step_t target;
		logic  emit;
	} uword_t;

	// Microcode ROM
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		case (step)
			ST_FETCH: w = '{op: OP_FETCH,     seq: SEQ_DISPATCH,      target: ST_FETCH, emit: 1'b0};
			ST_PUSH:  w = '{op: OP_PUSH,      seq: SEQ_JUMP,          target: ST_FETCH, emit: 1'b1};
			ST_POP:   w = '{op: OP_POP,       seq: SEQ_JUMP,          target: ST_FETCH, emit: 1'b1};
			ST_NOP:   w = '{op: OP_NOP,       seq: SEQ_JUMP,          target: ST_FETCH, emit: 1'b1};
			ST_SINIT: w = '{op: OP_SORT_INIT, seq: SEQ_NEXT,          target: ST_FETCH, emit: 1'b0};
			ST_OUTER: w = '{op: OP_OUTER,     seq: SEQ_IF_SORTED,     target: ST_TOP,   emit: 1'b0};
			ST_KEY:   w = '{op: OP_KEY,       seq: SEQ_NEXT,          target: ST_FETCH, emit: 1'b0};
			ST_CMP:   w = '{op: OP_SHIFT,     seq: SEQ_IF_SHIFT_MORE, target: ST_CMP,   emit: 1'b0};
			ST_PLACE: w = '{op: OP_PLACE,     seq: SEQ_JUMP,          target: ST_OUTER, emit: 1'b0};
			ST_TOP:   w = '{op: OP_TOP,       seq: SEQ_JUMP,          target: ST_FETCH, emit: 1'b1};
			default:  w = '{op: OP_NOP,       seq: SEQ_JUMP,          target: ST_FETCH, emit: 1'b0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== src/swis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module swis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/stack_with_insertion_sort.sv =====
// Top level: bounded signed stack with push, pop and in-place insertion sort.
`timescale 1ns / 1ps
`default_nettype none

// A bounded stack of DEPTH signed 32-bit words. Each command transaction (push, pop,
// sort) returns one response transaction carrying the popped word, the new top, the
// top recorded at the last sort, the entry count and full, empty and error flags.
// A microcoded sequencer drives a datapath around one RAM with one write and one
// registered read port. During a sort, each inserted entry needs one compare step
// per place it moves down plus one more unless it reaches the bottom. Sort time is
// set by the single RAM read port, one read per compare step. A new command is
// taken while the previous response still waits; a step that emits a response
// holds until the response register is free. Entries have no reset and need no
// clearing pass.
module stack_with_insertion_sort #(
	parameter int DEPTH = swis_pkg::DEPTH_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire swis_pkg::cmd_item_t cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output swis_pkg::rsp_item_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int W  = swis_pkg::WORD_W;

	// Sequencer state
	swis_pkg::step_t  step_q, step_d;
	swis_pkg::uword_t uw;
	logic             advance;
	logic             emit_fire;

	// Datapath registers
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [CW-1:0]       i_q, i_d;
	logic [CW-1:0]       j_q, j_d;
	logic signed [W-1:0] top_q, top_d;
	logic signed [W-1:0] saved_q, saved_d;
	logic signed [W-1:0] key_q, key_d;
	swis_pkg::rsp_item_t rsp_q, rsp_d;
	logic                rsp_valid_q;

	// RAM interface
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic signed [W-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic signed [W-1:0] ram_rdata;

	// Datapath controls
	logic signed [W-1:0] popped;
	logic                err;
	logic                shift;

	// Derived indices
	logic [CW-1:0] cnt_m1, cnt_m2, j_m1, j_m2;
	logic          is_full_d;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign j_m1   = j_q - CW'(1);
	assign j_m2   = j_q - CW'(2);

	assign uw        = swis_pkg::ucode(step_q);
	assign cmd_ready = (step_q == swis_pkg::ST_FETCH);

	// A step advances once its inputs are there and, if it emits, the response slot is free
	always_comb begin
		if (step_q == swis_pkg::ST_FETCH) begin
			advance = cmd_valid;
		end else if (uw.emit) begin
			advance = !rsp_valid_q || rsp_ready;
		end else begin
			advance = 1'b1;
		end
	end

	assign emit_fire = uw.emit && advance;

	// Shift test of the inner insertion loop
	assign shift = (uw.op == swis_pkg::OP_SHIFT) && (ram_rdata > key_q);

	// Next step
	always_comb begin
		step_d = step_q;
		case (uw.seq)
			swis_pkg::SEQ_NEXT: begin
				step_d = swis_pkg::step_t'(step_q + swis_pkg::STEP_W'(1));
			end
			swis_pkg::SEQ_JUMP: begin
				step_d = uw.target;
			end
			swis_pkg::SEQ_DISPATCH: begin
				case (cmd.command)
					swis_pkg::CMD_PUSH: step_d = swis_pkg::ST_PUSH;
					swis_pkg::CMD_POP:  step_d = swis_pkg::ST_POP;
					swis_pkg::CMD_SORT: step_d = swis_pkg::ST_SINIT;
					default:            step_d = swis_pkg::ST_NOP;
				endcase
			end
			swis_pkg::SEQ_IF_SORTED: begin
				if (i_q >= cnt_q) begin
					step_d = uw.target;
				end else begin
					step_d = swis_pkg::step_t'(step_q + swis_pkg::STEP_W'(1));
				end
			end
			swis_pkg::SEQ_IF_SHIFT_MORE: begin
				if (shift && (j_q > CW'(1))) begin
					step_d = uw.target;
				end else begin
					step_d = swis_pkg::step_t'(step_q + swis_pkg::STEP_W'(1));
				end
			end
			default: begin
				step_d = swis_pkg::ST_FETCH;
			end
		endcase
	end

	// Datapath controls decoded from the micro-operation
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = key_q;
		ram_raddr = '0;
		cnt_d     = cnt_q;
		top_d     = top_q;
		saved_d   = saved_q;
		i_d       = i_q;
		j_d       = j_q;
		key_d     = key_q;
		popped    = '0;
		err       = 1'b0;
		case (uw.op)
			swis_pkg::OP_FETCH: begin
				// prefetch the entry under the top for a pop
				ram_raddr = cnt_m2[AW-1:0];
				key_d     = cmd.push_value;
			end
			swis_pkg::OP_PUSH: begin
				if (cnt_q == CW'(DEPTH)) begin
					err = 1'b1;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[AW-1:0];
					ram_wdata = key_q;
					cnt_d     = cnt_q + CW'(1);
					top_d     = key_q;
				end
			end
			swis_pkg::OP_POP: begin
				// keep the prefetched entry in place while the response stalls
				ram_raddr = cnt_m2[AW-1:0];
				if (cnt_q == '0) begin
					err = 1'b1;
				end else begin
					popped = top_q;
					cnt_d  = cnt_m1;
					top_d  = (cnt_q == CW'(1)) ? '0 : ram_rdata;
				end
			end
			swis_pkg::OP_NOP: begin
			end
			swis_pkg::OP_SORT_INIT: begin
				saved_d = top_q;
				i_d     = CW'(1);
			end
			swis_pkg::OP_OUTER: begin
				if (i_q < cnt_q) begin
					ram_raddr = i_q[AW-1:0];
					j_d       = i_q;
				end else begin
					// sorted: fetch the new top
					ram_raddr = cnt_m1[AW-1:0];
				end
			end
			swis_pkg::OP_KEY: begin
				key_d     = ram_rdata;
				ram_raddr = j_m1[AW-1:0];
			end
			swis_pkg::OP_SHIFT: begin
				if (shift) begin
					ram_we    = 1'b1;
					ram_waddr = j_q[AW-1:0];
					ram_wdata = ram_rdata;
					j_d       = j_m1;
					ram_raddr = j_m2[AW-1:0];
				end
			end
			swis_pkg::OP_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = key_q;
				i_d       = i_q + CW'(1);
			end
			swis_pkg::OP_TOP: begin
				// keep the top entry in place while the response stalls
				ram_raddr = cnt_m1[AW-1:0];
				top_d     = (cnt_q == '0) ? '0 : ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// Response built from the state after the command
	assign is_full_d = (cnt_d == CW'(DEPTH));

	always_comb begin
		rsp_d.popped_value = popped;
		rsp_d.top_value    = top_d;
		rsp_d.past_top     = saved_d;
		rsp_d.entry_count  = swis_pkg::ENTRY_CNT_W'(cnt_d);
		rsp_d.is_full      = is_full_d;
		rsp_d.is_empty     = (cnt_d == '0);
		rsp_d.error        = err;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= swis_pkg::ST_FETCH;
			cnt_q       <= '0;
			top_q       <= '0;
			saved_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q  <= step_d;
				cnt_q   <= cnt_d;
				top_q   <= top_d;
				saved_q <= saved_d;
			end
			if (emit_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			i_q   <= i_d;
			j_q   <= j_d;
			key_q <= key_d;
		end
		if (emit_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Entry store
	swis_ram #(
		.WIDTH(W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

// ===== src/swis_checker.sv =====
// Port checker for the sorting stack, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module swis_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire swis_pkg::cmd_item_t cmd,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire swis_pkg::rsp_item_t rsp
);

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A stalled command holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("command changed while stalled");

	// An empty stack reports no entries, a zero top and is not full
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |->
			rsp.entry_count == '0 && rsp.top_value == '0 && !rsp.is_full)
		else $error("empty response inconsistent");

	// An error leaves the stack full or empty and pops nothing
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error |->
			(rsp.is_full || rsp.is_empty) && rsp.popped_value == '0)
		else $error("error response inconsistent");

endmodule

bind stack_with_insertion_sort swis_checker u_swis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd      (cmd),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire

// ===== test/stack_with_insertion_sort_test.sv =====
// Testbench for the sorting stack: random and directed commands checked against a local predictor.
`timescale 1ns / 1ps

module stack_with_insertion_sort_test;

	import swis_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	// Unused fourth command code: the block answers without changing state
	localparam logic [CMD_W-1:0] CMD_IDLE_CODE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 250;
	localparam int MAX_PRINTED = 40;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	stack_with_insertion_sort #(
		.DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: its own copy of the stack
	logic signed [WORD_W-1:0] stack_mem [DEPTH];
	int                       held = 0;
	logic signed [WORD_W-1:0] sort_top = '0;

	cmd_item_t cmd_backlog [$];
	rsp_item_t awaited_rsp [$];

	int  gen_depth = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_go = 1'b0;
	int  hold_cnt = 0;
	bit  cmd_took = 1'b0;
	int  stall_cycles = 0;

	int  failures = 0;
	int  cmds_taken = 0;
	int  rsps_checked = 0;
	int  sorts_seen = 0;
	int  push_refused = 0;
	int  pop_refused = 0;

	// Apply one command to the predicted stack and form the response it should give
	function automatic rsp_item_t stack_apply(cmd_item_t c);
		rsp_item_t                r;
		logic signed [WORD_W-1:0] key;
		int                       i;
		int                       j;
		r = '0;
		case (c.command)
			CMD_PUSH: begin
				if (held >= DEPTH) begin
					r.error = 1'b1;
				end else begin
					stack_mem[held] = c.push_value;
					held++;
				end
			end
			CMD_POP: begin
				if (held == 0) begin
					r.error = 1'b1;
				end else begin
					held--;
					r.popped_value = stack_mem[held];
				end
			end
			CMD_SORT: begin
				sort_top = (held == 0) ? '0 : stack_mem[held-1];
				// stable insertion sort, bottom smallest
				for (i = 1; i < held; i++) begin
					key = stack_mem[i];
					j = i;
					while (j > 0 && stack_mem[j-1] > key) begin
						stack_mem[j] = stack_mem[j-1];
						j--;
					end
					stack_mem[j] = key;
				end
			end
			default: ;
		endcase
		r.top_value   = (held == 0) ? '0 : stack_mem[held-1];
		r.past_top    = sort_top;
		r.entry_count = held[ENTRY_CNT_W-1:0];
		r.is_full     = (held == DEPTH);
		r.is_empty    = (held == 0);
		return r;
	endfunction

	task automatic note_failure(string msg);
		failures++;
		if (failures <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
		if (got !== want)
			note_failure($sformatf("response %0d %s got %h want %h", rsps_checked, name, got, want));
	endtask

	// Command driver: new transactions change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_took) begin
			if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd       <= cmd_backlog.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Response side: random stalls, and one long hold-off counted here
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
			rsp_ready <= 1'b0;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on accepted commands, check accepted responses
	always @(posedge clk) begin
		rsp_item_t want;
		rsp_item_t pred;
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= cmd_valid && cmd_ready;
			if (cmd_valid && cmd_ready) begin
				pred = stack_apply(cmd);
				awaited_rsp.push_back(pred);
				cmds_taken++;
				if (cmd.command == CMD_SORT) sorts_seen++;
				if (pred.error && cmd.command == CMD_PUSH) push_refused++;
				if (pred.error && cmd.command == CMD_POP) pop_refused++;
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					note_failure("response transaction with nothing outstanding");
				end else begin
					want = awaited_rsp.pop_front();
					compare_field("popped_value", rsp.popped_value, want.popped_value);
					compare_field("top_value", rsp.top_value, want.top_value);
					compare_field("past_top", rsp.past_top, want.past_top);
					compare_field("entry_count", WORD_W'(rsp.entry_count),
					              WORD_W'(want.entry_count));
					compare_field("is_full", WORD_W'(rsp.is_full), WORD_W'(want.is_full));
					compare_field("is_empty", WORD_W'(rsp.is_empty), WORD_W'(want.is_empty));
					compare_field("error", WORD_W'(rsp.error), WORD_W'(want.error));
				end
				rsps_checked++;
			end
		end
	end

	// Watchdog: cycles with work outstanding but no transaction moving
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
		    (cmd_backlog.size() == 0 && !cmd_valid && awaited_rsp.size() == 0)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic queue_command(logic [CMD_W-1:0] code, logic [WORD_W-1:0] value);
		cmd_item_t c;
		c.command    = code;
		c.push_value = value;
		cmd_backlog.push_back(c);
		if (code == CMD_PUSH && gen_depth < DEPTH) gen_depth++;
		if (code == CMD_POP && gen_depth > 0) gen_depth--;
	endtask

	// Words: full range, a narrow band for duplicates, and the extremes
	function automatic logic [WORD_W-1:0] pick_word();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) return $urandom();
		if (sel < 75) return $urandom_range(8) - 4;
		case ($urandom_range(4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// One chunk: mostly fill, sort, unwind; sometimes loose commands
	task automatic gen_sequence();
		int target;
		int n;
		if ($urandom_range(99) < 78) begin
			target = ($urandom_range(99) < 20) ? DEPTH : $urandom_range(DEPTH);
			while (gen_depth < target) queue_command(CMD_PUSH, pick_word());
			if (gen_depth == DEPTH && $urandom_range(99) < 60)
				queue_command(CMD_PUSH, pick_word());
			queue_command(CMD_SORT, pick_word());
			if ($urandom_range(99) < 25) begin
				queue_command(CMD_PUSH, pick_word());
				queue_command(CMD_SORT, pick_word());
			end
			n = $urandom_range(gen_depth);
			repeat (n) queue_command(CMD_POP, pick_word());
			if (gen_depth == 0 && $urandom_range(99) < 50)
				queue_command(CMD_POP, pick_word());
		end else begin
			repeat ($urandom_range(1, 4)) queue_command(CMD_W'($urandom_range(3)), pick_word());
		end
	endtask

	task automatic fill_phase(int count);
		int start;
		start = cmd_backlog.size();
		while (cmd_backlog.size() - start < count) gen_sequence();
	endtask

	task automatic drain();
		while (cmd_backlog.size() > 0 || cmd_valid || awaited_rsp.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [WORD_W-1:0] seed_words [10];
		seed_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
		               32'h5, 32'h5, 32'hFFFF_FFFB, 32'h8000_0001, 32'h7FFF_FFFE};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty-stack cases, fill to full with extremes, refused push, unused code, sort, pops
		queue_command(CMD_POP, 32'hFFFF_FFFF);
		queue_command(CMD_SORT, 32'h0);
		queue_command(CMD_IDLE_CODE, 32'hFFFF_FFFF);
		foreach (seed_words[k]) queue_command(CMD_PUSH, seed_words[k]);
		repeat (DEPTH - 10) queue_command(CMD_PUSH, pick_word());
		queue_command(CMD_PUSH, 32'h1234_5678);
		queue_command(CMD_IDLE_CODE, 32'h0);
		queue_command(CMD_SORT, 32'h0);
		queue_command(CMD_POP, 32'h0);
		queue_command(CMD_POP, 32'h0);
		drain();

		// Back to back
		fill_phase(150);
		drain();

		// Long receiver hold-off while the sender keeps offering
		fill_phase(40);
		hold_go = 1'b1;
		drain();

		// Sender idling
		send_idle_pct = 62;
		fill_phase(150);
		drain();

		// Receiver stalling
		send_idle_pct  = 0;
		recv_stall_pct = 62;
		fill_phase(150);
		drain();

		// Both sides idling lightly
		send_idle_pct  = 13;
		recv_stall_pct = 13;
		fill_phase(160);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_rsp.size() != 0)
			note_failure($sformatf("%0d responses never arrived", awaited_rsp.size()));

		$display("%0d commands and %0d responses checked across five idling patterns",
		         cmds_taken, rsps_checked);
		$display("including a %0d-cycle receiver hold-off; %0d sorts, %0d refused pushes, %0d refused pops",
		         HOLD_CYCLES, sorts_seen, push_refused, pop_refused);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", failures);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/swis_pkg.sv
src/swis_ram.sv
src/stack_with_insertion_sort.sv
src/swis_checker.sv
test/stack_with_insertion_sort_test.sv
